/* hdl/ggcg_pkg.sv */
// ggcg_pkg: shared constants, codes and saturation helpers for the
// gauss green cell gradient engine; no dependencies
package ggcg_pkg;

   localparam int DEF_MAX_CELLS = 1024;
   localparam int DEF_MAX_VARS  = 8;
   localparam int DEF_DIMS      = 3;

   localparam int CMD_W   = 2;
   localparam int CELL_W  = 10;
   localparam int VAR_W   = 3;
   localparam int VAL_W   = 32;
   localparam int WGT_W   = 17;
   localparam int AREA_W  = 32;
   localparam int NRM_W   = 16;
   localparam int GRAD_W  = 32;
   localparam int ACC_W   = 48;
   localparam int VIU_W   = 4;
   localparam int CIU_W   = 11;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 11;

   localparam int MUL_W   = 33;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int SUM_W   = 50;
   localparam int T_W     = 49;
   localparam int FV_W    = 50;
   localparam int PART_W  = 81;

   localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(65536);

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_VALUE = 2'd0,
      CMD_LOAD_INVVOL = 2'd1,
      CMD_FACE = 2'd2,
      CMD_READ = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VARS_IN_USE = 1'd0,
      CSR_CELLS_IN_USE = 1'd1
   } csr_idx_type;

   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W+3:0] x);
      logic signed [ACC_W+3:0] hi;
      logic signed [ACC_W+3:0] lo;
      hi = (ACC_W+4)'(signed'({1'b0, {(ACC_W-1){1'b1}}}));
      lo = -hi - (ACC_W+4)'(1);
      if (x > hi) return hi[ACC_W-1:0];
      if (x < lo) return lo[ACC_W-1:0];
      return x[ACC_W-1:0];
   endfunction

   function automatic logic signed [GRAD_W-1:0] sat_grad(input logic signed [PART_W-17:0] x);
      logic signed [PART_W-17:0] hi;
      logic signed [PART_W-17:0] lo;
      hi = (PART_W-16)'(signed'({1'b0, {(GRAD_W-1){1'b1}}}));
      lo = -hi - (PART_W-16)'(1);
      if (x > hi) return hi[GRAD_W-1:0];
      if (x < lo) return lo[GRAD_W-1:0];
      return x[GRAD_W-1:0];
   endfunction

endpackage

/* hdl/gauss_green_cell_gradient.sv */
// gauss_green_cell_gradient: top level, sequencer around one shared 33x33
// multiplier with value, inverse volume and accumulator memories; uses ggcg_pkg
//
// channel  direction  handshake              contents
// req_     in         req_valid/req_ready    command and face or cell fields
// rsp_     out        rsp_valid/rsp_ready    cell, variable and gradients
// csr_     in         csr_valid/csr_ready    register index and write data
//
// loads are written when accepted; a read steps through the read states and may wait at the output,
// a face repeats its states once per variable in use, all on one multiplier
// req_ready is high only while the sequencer is idle; a read result waits in
// the output register and stalls a later read only at its hand-off
// reset returns the sequencer to idle, clears the output valid and sets the
// configuration registers to 1 variable and 1024 cells; memories hold undefined data until written
module gauss_green_cell_gradient
   import ggcg_pkg::*;
#(
   parameter int MAX_CELLS = DEF_MAX_CELLS,
   parameter int MAX_VARS  = DEF_MAX_VARS,
   parameter int DIMS      = DEF_DIMS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CMD_W-1:0]         req_command,
   input  logic [CELL_W-1:0]        req_cell_index,
   input  logic [VAR_W-1:0]         req_var_index,
   input  logic signed [VAL_W-1:0]  req_value,
   input  logic [CELL_W-1:0]        req_left_cell,
   input  logic [CELL_W-1:0]        req_right_cell,
   input  logic [WGT_W-1:0]         req_interp_weight,
   input  logic [AREA_W-1:0]        req_face_area,
   input  logic signed [NRM_W-1:0]  req_normal_x,
   input  logic signed [NRM_W-1:0]  req_normal_y,
   input  logic signed [NRM_W-1:0]  req_normal_z,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [CELL_W-1:0]        rsp_read_cell,
   output logic [VAR_W-1:0]         rsp_read_var,
   output logic signed [GRAD_W-1:0] rsp_grad_x,
   output logic signed [GRAD_W-1:0] rsp_grad_y,
   output logic signed [GRAD_W-1:0] rsp_grad_z,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DAT_W-1:0]     csr_data
);

   localparam int CW  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int VW  = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
   localparam int AW  = VW + CW;
   localparam int NCW = (CW + 1 > CIU_W) ? CW + 1 : CIU_W;
   localparam int NVW = VIU_W + 1;
   localparam int DW  = (DIMS > 1) ? $clog2(DIMS) : 1;

   typedef logic [DIMS-1:0][ACC_W-1:0] acc_row_type;

   typedef enum logic [4:0] {
      S_IDLE, S_F_RD, S_F_M1, S_F_M2, S_F_M3, S_F_M4, S_F_M5,
      S_F_DH, S_F_DL, S_F_DS, S_F_ARL, S_F_UL, S_F_ARR, S_F_UR,
      S_G_RD, S_G_H, S_G_L, S_G_S, S_G_OUT
   } state_type;

   state_type state_ff;

   logic [VIU_W-1:0] vars_in_use_ff;
   logic [CIU_W-1:0] cells_in_use_ff;

   logic [CW-1:0]  cell_ff, lc_ff, rc_ff;
   logic [VW-1:0]  var_ff;
   logic [NVW-1:0] v_ff;
   logic [DW-1:0]  d_ff;
   logic [NVW-1:0] nvars_ff;
   logic [WGT_W-1:0] w_ff, wr_ff;
   logic [AREA_W-1:0] area_ff;
   logic signed [NRM_W-1:0] nrm_ff [DIMS];
   logic [CELL_W-1:0] rcell_ff;
   logic [VAR_W-1:0]  rvar_ff;

   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [VAL_W-1:0]  uf_ff;
   logic signed [T_W-1:0]    t_ff;
   logic signed [FV_W-1:0]   fval_ff [DIMS];
   logic signed [PART_W-1:0] part_ff;
   logic signed [GRAD_W-1:0] gtmp_ff [DIMS];

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff;

   logic signed [VAL_W-1:0] cval_mem [2**AW];
   logic signed [VAL_W-1:0] ivol_mem [2**CW];
   acc_row_type             acc_mem  [2**AW];

   logic signed [VAL_W-1:0] cv_a_ff, cv_b_ff, iv_ff;
   acc_row_type             acc_q_ff;

   logic [AW-1:0] cv_ra, cv_rb, acc_ra, acc_wa, cv_wa;
   logic          acc_we, cv_we, iv_we;
   acc_row_type   acc_wd;
   logic [CW-1:0] iv_wa;

   logic [NCW-1:0] ncells;
   logic [NVW-1:0] nvars;
   logic           req_acc;
   logic           cell_ok, var_ok, lc_ok, rc_ok;
   logic [CW-1:0]  req_cell, req_lc, req_rc;
   logic [VW-1:0]  req_var;
   logic [WGT_W-1:0] w_clamp;
   logic           d_last;

   assign ncells = (NCW'(cells_in_use_ff) < NCW'(MAX_CELLS)) ? NCW'(cells_in_use_ff)
                                                             : NCW'(MAX_CELLS);
   assign nvars  = (NVW'(vars_in_use_ff) < NVW'(MAX_VARS)) ? NVW'(vars_in_use_ff)
                                                           : NVW'(MAX_VARS);
   assign req_ready = (state_ff == S_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign cell_ok = NCW'(req_cell_index) < ncells;
   assign lc_ok   = NCW'(req_left_cell) < ncells;
   assign rc_ok   = NCW'(req_right_cell) < ncells;
   assign var_ok  = NVW'(req_var_index) < NVW'(MAX_VARS);
   assign req_cell = CW'(req_cell_index);
   assign req_lc   = CW'(req_left_cell);
   assign req_rc   = CW'(req_right_cell);
   assign req_var  = VW'(req_var_index);
   assign w_clamp  = (req_interp_weight > WGT_ONE) ? WGT_ONE : req_interp_weight;
   assign d_last   = (d_ff == DW'(DIMS - 1));

   // shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_F_M1: begin
            mul_a = MUL_W'(cv_a_ff);
            mul_b = MUL_W'(signed'({1'b0, w_ff}));
         end
         S_F_M2: begin
            mul_a = MUL_W'(cv_b_ff);
            mul_b = MUL_W'(signed'({1'b0, wr_ff}));
         end
         S_F_M4: begin
            mul_a = MUL_W'(uf_ff);
            mul_b = signed'({1'b0, area_ff});
         end
         S_F_DH: begin
            mul_a = MUL_W'(signed'(t_ff[T_W-1:17]));
            mul_b = MUL_W'(nrm_ff[d_ff]);
         end
         S_F_DL: begin
            mul_a = MUL_W'(signed'({1'b0, t_ff[16:0]}));
            mul_b = MUL_W'(nrm_ff[d_ff]);
         end
         S_G_H: begin
            mul_a = MUL_W'(signed'(acc_q_ff[d_ff][ACC_W-1:24]));
            mul_b = MUL_W'(iv_ff);
         end
         S_G_L: begin
            mul_a = MUL_W'(signed'({1'b0, acc_q_ff[d_ff][23:0]}));
            mul_b = MUL_W'(iv_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // memory ports
   always_comb begin
      cv_ra  = {v_ff[VW-1:0], lc_ff};
      cv_rb  = {v_ff[VW-1:0], rc_ff};
      acc_ra = {var_ff, cell_ff};
      if (state_ff == S_F_ARL) acc_ra = {v_ff[VW-1:0], lc_ff};
      if (state_ff == S_F_ARR) acc_ra = {v_ff[VW-1:0], rc_ff};
      cv_we = req_acc && (cmd_type'(req_command) == CMD_LOAD_VALUE) && cell_ok && var_ok;
      cv_wa = {req_var, req_cell};
      iv_we = req_acc && (cmd_type'(req_command) == CMD_LOAD_INVVOL) && cell_ok;
      iv_wa = req_cell;
      acc_we = cv_we;
      acc_wa = {req_var, req_cell};
      acc_wd = '0;
      for (int i = 0; i < DIMS; i++) begin
         if (state_ff == S_F_UL) begin
            acc_wd[i] = sat_acc((ACC_W+4)'(signed'(acc_q_ff[i])) + (ACC_W+4)'(fval_ff[i]));
         end else if (state_ff == S_F_UR) begin
            acc_wd[i] = sat_acc((ACC_W+4)'(signed'(acc_q_ff[i])) - (ACC_W+4)'(fval_ff[i]));
         end
      end
      if (state_ff == S_F_UL) begin
         acc_we = 1'b1;
         acc_wa = {v_ff[VW-1:0], lc_ff};
      end else if (state_ff == S_F_UR) begin
         acc_we = 1'b1;
         acc_wa = {v_ff[VW-1:0], rc_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cv_we) cval_mem[cv_wa] <= req_value;
      cv_a_ff <= cval_mem[cv_ra];
      cv_b_ff <= cval_mem[cv_rb];
   end

   always_ff @(posedge clock) begin
      if (iv_we) ivol_mem[iv_wa] <= req_value;
      iv_ff <= ivol_mem[cell_ff];
   end

   always_ff @(posedge clock) begin
      if (acc_we) acc_mem[acc_wa] <= acc_wd;
      acc_q_ff <= acc_mem[acc_ra];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vars_in_use_ff  <= VIU_W'(1);
         cells_in_use_ff <= CIU_W'(1024);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_VARS_IN_USE:  vars_in_use_ff  <= csr_data[VIU_W-1:0];
            CSR_CELLS_IN_USE: cells_in_use_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready && state_ff != S_G_OUT) rsp_valid <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  cell_ff  <= req_cell;
                  var_ff   <= req_var;
                  rcell_ff <= req_cell_index;
                  rvar_ff  <= req_var_index;
                  lc_ff    <= req_lc;
                  rc_ff    <= req_rc;
                  w_ff     <= w_clamp;
                  wr_ff    <= WGT_ONE - w_clamp;
                  area_ff  <= req_face_area;
                  nvars_ff <= nvars;
                  nrm_ff[0] <= req_normal_x;
                  nrm_ff[1] <= req_normal_y;
                  if (DIMS > 2) nrm_ff[DIMS-1] <= req_normal_z;
                  v_ff <= '0;
                  d_ff <= '0;
                  if (cmd_type'(req_command) == CMD_READ && cell_ok && var_ok) begin
                     state_ff <= S_G_RD;
                  end else if (cmd_type'(req_command) == CMD_FACE && lc_ok && rc_ok
                               && nvars != '0) begin
                     state_ff <= S_F_RD;
                  end
               end
            end
            S_F_RD: state_ff <= S_F_M1;
            S_F_M1: state_ff <= S_F_M2;
            S_F_M2: begin
               sum_ff   <= prod_ff[SUM_W-1:0] + SUM_W'(32768);
               state_ff <= S_F_M3;
            end
            S_F_M3: begin
               uf_ff    <= VAL_W'((sum_ff + prod_ff[SUM_W-1:0]) >>> 16);
               state_ff <= S_F_M4;
            end
            S_F_M4: state_ff <= S_F_M5;
            S_F_M5: begin
               t_ff     <= T_W'((prod_ff + PROD_W'(32768)) >>> 16);
               d_ff     <= '0;
               state_ff <= S_F_DH;
            end
            S_F_DH: state_ff <= S_F_DL;
            S_F_DL: begin
               part_ff  <= PART_W'(prod_ff) <<< 17;
               state_ff <= S_F_DS;
            end
            S_F_DS: begin
               fval_ff[d_ff] <= FV_W'((part_ff + PART_W'(prod_ff) + PART_W'(16384)) >>> 15);
               if (d_last) begin
                  state_ff <= S_F_ARL;
               end else begin
                  d_ff     <= d_ff + DW'(1);
                  state_ff <= S_F_DH;
               end
            end
            S_F_ARL: state_ff <= S_F_UL;
            S_F_UL:  state_ff <= S_F_ARR;
            S_F_ARR: state_ff <= S_F_UR;
            S_F_UR: begin
               v_ff <= v_ff + NVW'(1);
               if (v_ff + NVW'(1) < nvars_ff) state_ff <= S_F_RD;
               else state_ff <= S_IDLE;
            end
            S_G_RD: begin
               d_ff     <= '0;
               state_ff <= S_G_H;
            end
            S_G_H: state_ff <= S_G_L;
            S_G_L: begin
               part_ff  <= PART_W'(prod_ff) <<< 24;
               state_ff <= S_G_S;
            end
            S_G_S: begin
               gtmp_ff[d_ff] <= sat_grad((PART_W-16)'((part_ff + PART_W'(prod_ff)
                                          + PART_W'(32768)) >>> 16));
               if (d_last) begin
                  state_ff <= S_G_OUT;
               end else begin
                  d_ff     <= d_ff + DW'(1);
                  state_ff <= S_G_H;
               end
            end
            S_G_OUT: begin
               if (!rsp_valid || rsp_ready) begin
                  rsp_valid     <= 1'b1;
                  rsp_read_cell <= rcell_ff;
                  rsp_read_var  <= rvar_ff;
                  rsp_grad_x    <= gtmp_ff[0];
                  rsp_grad_y    <= gtmp_ff[1];
                  rsp_grad_z    <= (DIMS > 2) ? gtmp_ff[DIMS-1] : '0;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking testbench for gauss_green_cell_gradient with a scoreboard
// class that predicts gradient read-backs; depends on ggcg_pkg and the block
`timescale 1ns / 1ps

module tb_top;
   import ggcg_pkg::*;

   localparam int LIMIT = 3000000;
   localparam int SETTLE = 400;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      cmd_type                 cmd;
      logic [CELL_W-1:0]       cell_idx;
      logic [VAR_W-1:0]        var_idx;
      logic signed [VAL_W-1:0] value;
      logic [CELL_W-1:0]       lc;
      logic [CELL_W-1:0]       rc;
      logic [WGT_W-1:0]        wgt;
      logic [AREA_W-1:0]       area;
      logic signed [NRM_W-1:0] nx;
      logic signed [NRM_W-1:0] ny;
      logic signed [NRM_W-1:0] nz;
   } grad_req_type;

   typedef struct {
      logic [CELL_W-1:0]        cell_idx;
      logic [VAR_W-1:0]         var_idx;
      logic signed [GRAD_W-1:0] g [3];
   } grad_rsp_type;

   class gradient_board;
      logic signed [VAL_W-1:0]  cell_vals [DEF_MAX_VARS][DEF_MAX_CELLS];
      logic signed [ACC_W-1:0]  grad_sums [DEF_MAX_VARS][3][DEF_MAX_CELLS];
      logic signed [VAL_W-1:0]  inv_vols [DEF_MAX_CELLS];
      bit                       val_set [DEF_MAX_VARS][DEF_MAX_CELLS];
      bit                       vol_set [DEF_MAX_CELLS];
      logic [VIU_W-1:0]         vars_reg;
      logic [CIU_W-1:0]         cells_reg;
      grad_rsp_type             pending_grads [$];
      int                       errors;
      int                       results;

      function new();
         vars_reg = 1;
         cells_reg = 1024;
         errors = 0;
         results = 0;
      endfunction

      function int ncells();
         return cells_reg > DEF_MAX_CELLS ? DEF_MAX_CELLS : int'(cells_reg);
      endfunction

      function int nvars();
         return vars_reg > DEF_MAX_VARS ? DEF_MAX_VARS : int'(vars_reg);
      endfunction

      function void set_reg(csr_idx_type idx, logic [CSR_DAT_W-1:0] d);
         if (idx == CSR_VARS_IN_USE) vars_reg = d[VIU_W-1:0];
         else cells_reg = d[CIU_W-1:0];
      endfunction

      // true when the item would touch storage never written
      function bit unsafe(grad_req_type it);
         if (it.cmd == CMD_READ)
            return it.cell_idx < ncells()
                   && !(val_set[it.var_idx][it.cell_idx] && vol_set[it.cell_idx]);
         if (it.cmd == CMD_FACE && it.lc < ncells() && it.rc < ncells())
            for (int v = 0; v < nvars(); v++)
               if (!val_set[v][it.lc] || !val_set[v][it.rc]) return 1;
         return 0;
      endfunction

      function wide_type rnd(wide_type x, int k);
         return (x + (wide_type'(1) <<< (k - 1))) >>> k;
      endfunction

      function logic signed [ACC_W-1:0] sat48(wide_type x);
         wide_type hi;
         hi = (wide_type'(1) <<< 47) - 1;
         if (x > hi) return hi[ACC_W-1:0];
         if (x < -hi - 1) return ACC_W'(-hi - 1);
         return x[ACC_W-1:0];
      endfunction

      function logic signed [GRAD_W-1:0] sat32(wide_type x);
         if (x > wide_type'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
         if (x < -wide_type'(32'sh7FFFFFFF) - 1) return 32'sh80000000;
         return x[GRAD_W-1:0];
      endfunction

      function void note_request(grad_req_type it);
         grad_rsp_type r;
         wide_type w, uf, t, val;
         wide_type nrm [3];
         case (it.cmd)
            CMD_LOAD_VALUE: if (it.cell_idx < ncells()) begin
               cell_vals[it.var_idx][it.cell_idx] = it.value;
               val_set[it.var_idx][it.cell_idx] = 1;
               for (int d = 0; d < 3; d++) grad_sums[it.var_idx][d][it.cell_idx] = '0;
            end
            CMD_LOAD_INVVOL: if (it.cell_idx < ncells()) begin
               inv_vols[it.cell_idx] = it.value;
               vol_set[it.cell_idx] = 1;
            end
            CMD_READ: if (it.cell_idx < ncells()) begin
               r.cell_idx = it.cell_idx;
               r.var_idx = it.var_idx;
               for (int d = 0; d < 3; d++)
                  r.g[d] = sat32(rnd(wide_type'(grad_sums[it.var_idx][d][it.cell_idx])
                                     * wide_type'(inv_vols[it.cell_idx]), 16));
               pending_grads.push_back(r);
            end
            default: if (it.lc < ncells() && it.rc < ncells()) begin
               w = it.wgt > WGT_ONE ? wide_type'(WGT_ONE) : wide_type'(it.wgt);
               nrm[0] = wide_type'(it.nx);
               nrm[1] = wide_type'(it.ny);
               nrm[2] = wide_type'(it.nz);
               for (int v = 0; v < nvars(); v++) begin
                  uf = rnd(wide_type'(cell_vals[v][it.lc]) * w
                           + wide_type'(cell_vals[v][it.rc]) * (65536 - w), 16);
                  t = rnd(uf * wide_type'(it.area), 16);
                  for (int d = 0; d < 3; d++) begin
                     val = rnd(t * nrm[d], 15);
                     grad_sums[v][d][it.lc] = sat48(wide_type'(grad_sums[v][d][it.lc]) + val);
                     grad_sums[v][d][it.rc] = sat48(wide_type'(grad_sums[v][d][it.rc]) - val);
                  end
               end
            end
         endcase
      endfunction

      function void check_result(grad_rsp_type got);
         grad_rsp_type exp_r;
         results++;
         if (pending_grads.size() == 0) begin
            $display("%0t: unexpected result cell %0d var %0d", $time, got.cell_idx,
                     got.var_idx);
            errors++;
            return;
         end
         exp_r = pending_grads.pop_front();
         if (got.cell_idx !== exp_r.cell_idx) begin
            $display("%0t: read_cell expected %0d actual %0d", $time, exp_r.cell_idx,
                     got.cell_idx);
            errors++;
         end
         if (got.var_idx !== exp_r.var_idx) begin
            $display("%0t: read_var expected %0d actual %0d", $time, exp_r.var_idx, got.var_idx);
            errors++;
         end
         for (int d = 0; d < 3; d++)
            if (got.g[d] !== exp_r.g[d]) begin
               $display("%0t: grad[%0d] expected %0d actual %0d", $time, d, exp_r.g[d], got.g[d]);
               errors++;
            end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   logic [CMD_W-1:0] req_command = '0;
   logic [CELL_W-1:0] req_cell_index = '0, req_left_cell = '0, req_right_cell = '0;
   logic [VAR_W-1:0] req_var_index = '0;
   logic signed [VAL_W-1:0] req_value = '0;
   logic [WGT_W-1:0] req_interp_weight = '0;
   logic [AREA_W-1:0] req_face_area = '0;
   logic signed [NRM_W-1:0] req_normal_x = '0, req_normal_y = '0, req_normal_z = '0;
   logic rsp_valid, rsp_ready = 0;
   logic [CELL_W-1:0] rsp_read_cell;
   logic [VAR_W-1:0] rsp_read_var;
   logic signed [GRAD_W-1:0] rsp_grad_x, rsp_grad_y, rsp_grad_z;
   logic csr_valid = 0, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   gradient_board board = new();
   int cycles = 0;
   int sent = 0;
   bit no_gaps = 0;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   gauss_green_cell_gradient uut (.*);

   task automatic send_request(grad_req_type it);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_command <= it.cmd;
      req_cell_index <= it.cell_idx;
      req_var_index <= it.var_idx;
      req_value <= it.value;
      req_left_cell <= it.lc;
      req_right_cell <= it.rc;
      req_interp_weight <= it.wgt;
      req_face_area <= it.area;
      req_normal_x <= it.nx;
      req_normal_y <= it.ny;
      req_normal_z <= it.nz;
      do @(posedge clock); while (!(req_valid && req_ready));
      board.note_request(it);
      sent++;
   endtask

   task automatic write_reg(csr_idx_type idx, logic [CSR_DAT_W-1:0] d);
      req_valid <= 0;
      while (board.pending_grads.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 0;
      board.set_reg(idx, d);
   endtask

   function automatic grad_req_type make_req(cmd_type c, int cell_num, int v, logic [31:0] val,
                                             int lc, int rc, int w, logic [31:0] area,
                                             int nx, int ny, int nz);
      grad_req_type it;
      it.cmd = c;
      it.cell_idx = CELL_W'(cell_num);
      it.var_idx = VAR_W'(v);
      it.value = val;
      it.lc = CELL_W'(lc);
      it.rc = CELL_W'(rc);
      it.wgt = WGT_W'(w);
      it.area = area;
      it.nx = NRM_W'(nx);
      it.ny = NRM_W'(ny);
      it.nz = NRM_W'(nz);
      return it;
   endfunction

   function automatic int pick_cell();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return $urandom_range(0, 7);
      if (r < 9) return $urandom_range(0, board.ncells() > 0 ? board.ncells() - 1 : 0) % 1024;
      return $urandom_range(0, 1023);
   endfunction

   function automatic grad_req_type random_req();
      grad_req_type it;
      int r;
      r = $urandom_range(0, 99);
      it.cmd = r < 30 ? CMD_LOAD_VALUE : r < 40 ? CMD_LOAD_INVVOL : r < 75 ? CMD_FACE : CMD_READ;
      it.cell_idx = CELL_W'(pick_cell());
      it.var_idx = VAR_W'($urandom_range(0, 7));
      it.value = $urandom();
      if ($urandom_range(0, 7) == 0) it.value = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      it.lc = CELL_W'(pick_cell());
      it.rc = $urandom_range(0, 9) == 0 ? it.lc : CELL_W'(pick_cell());
      it.wgt = $urandom_range(0, 3) == 0 ? WGT_W'($urandom()) : WGT_W'($urandom_range(0, 65536));
      it.area = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h40000);
      it.nx = NRM_W'($urandom());
      it.ny = NRM_W'($urandom());
      it.nz = NRM_W'($urandom());
      if (board.unsafe(it)) begin
         // fill the gap first so the face or read becomes legal later
         it.cmd = $urandom_range(0, 1) ? CMD_LOAD_VALUE : CMD_LOAD_INVVOL;
         if (it.cell_idx >= board.ncells() || $urandom_range(0, 1)) it.cell_idx = it.lc;
      end
      return it;
   endfunction

   initial begin
      int rnd_vars [8] = '{8, 1, 0, 15, 3, 8, 5, 8};
      int rnd_cells [8] = '{1024, 1024, 16, 2, 1, 2047, 0, 8};
      int counts [8] = '{320, 220, 200, 200, 150, 320, 60, 230};
      repeat (7) @(posedge clock);
      reset <= 0;

      // directed part: extremes, saturation, same-cell face, clear on load
      write_reg(CSR_VARS_IN_USE, 2);
      send_request(make_req(CMD_LOAD_VALUE, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_LOAD_VALUE, 0, 1, 32'h80000000, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_LOAD_VALUE, 1, 0, 32'h80000000, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_LOAD_VALUE, 1, 1, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_LOAD_VALUE, 1023, 0, 32'h0, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_LOAD_VALUE, 1023, 1, 32'h00010000, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_LOAD_INVVOL, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_LOAD_INVVOL, 1, 0, 32'h80000000, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_LOAD_INVVOL, 1023, 0, 32'h00010000, 0, 0, 0, 0, 0, 0, 0));
      repeat (3)
         send_request(make_req(CMD_FACE, 0, 0, 0, 0, 1, 0, 32'hFFFFFFFF, -32768, 32767, -32768));
      send_request(make_req(CMD_FACE, 0, 0, 0, 1, 0, 65536, 32'hFFFFFFFF, 32767, 32767, 32767));
      send_request(make_req(CMD_FACE, 0, 0, 0, 0, 0, 131071, 32'h00020000, 16384, -1, 0));
      send_request(make_req(CMD_FACE, 0, 0, 0, 1023, 1, 32768, 32'h00010000, 16384, 16384, -16384));
      send_request(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_READ, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_READ, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_LOAD_VALUE, 0, 0, 32'h00030000, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      write_reg(CSR_CELLS_IN_USE, 2);
      send_request(make_req(CMD_READ, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_FACE, 0, 0, 0, 0, 1023, 0, 32'h10000, 100, 100, 100));
      send_request(make_req(CMD_LOAD_VALUE, 5, 0, 32'h1234, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_READ, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0));

      for (int p = 0; p < 8; p++) begin
         write_reg(CSR_VARS_IN_USE, CSR_DAT_W'(rnd_vars[p]));
         write_reg(CSR_CELLS_IN_USE, CSR_DAT_W'(rnd_cells[p]));
         for (int i = 0; i < counts[p]; i++) begin
            if (i % 100 == 50) no_gaps = ~no_gaps;
            send_request(random_req());
         end
      end
      req_valid <= 0;
      while (board.pending_grads.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      $display("covered %0d transactions and %0d gradient reads over 8 register settings",
               sent, board.results);
      $display("with variable counts 0 to 15 and cell counts 0 to 2047");
      if (board.errors == 0 && board.pending_grads.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   initial begin
      grad_rsp_type got;
      int gap;
      @(posedge clock);
      forever begin
         gap = no_gaps ? 0 : $urandom_range(0, 19);
         if (gap > 0) begin
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         got.cell_idx = rsp_read_cell;
         got.var_idx = rsp_read_var;
         got.g[0] = rsp_grad_x;
         got.g[1] = rsp_grad_y;
         got.g[2] = rsp_grad_z;
         board.check_result(got);
      end
   end

endmodule
